/* rtl/rfc_pkg.sv */
package rfc_pkg;

  // Frame layout and buffer limits
  localparam int RX_BUFFER_BYTES = 64;
  localparam int LENGTH_OFFSET   = 16;
  localparam int RX_MARGIN       = 17;
  localparam int SEQ_OFFSET      = 2;
  localparam int HEADER_BYTES    = 2;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE   = 8'hBB;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  // Byte offset counter and the width used for offset arithmetic
  localparam int POS_W = 9;
  localparam int CMP_W = POS_W + 1;

  // Length check: LENGTH_OFFSET + 1 + L must stay below this
  localparam int LEN_LIMIT = RX_BUFFER_BYTES - RX_MARGIN;

  // Verdict codes
  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_HEADER = 3'd1,
    ERR_LENGTH = 3'd2,
    ERR_TAIL   = 3'd3,
    ERR_CRC    = 3'd4
  } err_code_e;

endpackage

/* rtl/rfc_crc8.sv */
module rfc_crc8
  import rfc_pkg::*;
(
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);

  // Reflected CRC-8, one byte per call, eight bit steps unrolled
  always_comb begin
    logic [7:0] c;
    c = crc_i ^ byte_i;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

/* rtl/rs485_frame_checker.sv */
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   rx_byte[7:0]                                frame_start
// m_axis    out  error_code[2:0] payload_length[10:3]        frame_ok
//                sequence_number[18:11], zero pad [23:19]
//
// A byte lands in the input register at its accepting edge; its verdict
// is registered in the result register when the check stage advances.
// One byte is accepted every cycle unless a result waits; the byte-to-byte loop is
// the CRC-8 and offset state update. A verdict appears at most once per frame.
// Reset leaves the checker waiting for a byte marked as frame start.
// A result waiting on m_axis_tready holds the check stage, and with it the input.
module rs485_frame_checker
  import rfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic [0:0]  s_axis_tuser,   // frame_start[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // error_code[2:0], payload_length[10:3],
                                      // sequence_number[18:11], zeros[23:19]
  output logic [0:0]  m_axis_tuser    // frame_ok[0]
);

  // Input register
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_start_q;

  // Frame state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       seq_q, seq_d;
  logic             fin_q, fin_d;

  // Result register
  logic             out_valid_q;
  logic             out_ok_q;
  err_code_e        out_code_q;
  logic [7:0]       out_len_q;
  logic [7:0]       out_seq_q;

  logic             advance;
  logic             verdict;
  err_code_e        code;
  logic [7:0]       crc_next;

  // Effective state after a frame start
  logic [POS_W-1:0] pos_e;
  logic [7:0]       crc_e;
  logic [7:0]       len_e;
  logic [7:0]       seq_e;
  logic             fin_e;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] tail_w;
  logic [CMP_W-1:0] end_w;

  // Check stage moves when the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  rfc_crc8 u_crc (
    .crc_i  (crc_e),
    .byte_i (in_byte_q),
    .crc_o  (crc_next)
  );

  // Frame check for the byte in the input register
  always_comb begin
    pos_e   = in_start_q ? '0 : pos_q;
    crc_e   = in_start_q ? '0 : crc_q;
    len_e   = in_start_q ? '0 : len_q;
    seq_e   = in_start_q ? '0 : seq_q;
    fin_e   = in_start_q ? 1'b0 : fin_q;

    pos_w   = {1'b0, pos_e};
    verdict = 1'b0;
    code    = ERR_OK;
    len_d   = len_e;
    seq_d   = seq_e;
    tail_w  = CMP_W'(LENGTH_OFFSET + 1) + {{(CMP_W-8){1'b0}}, len_e};
    end_w   = CMP_W'(LENGTH_OFFSET + 1) + {{(CMP_W-8){1'b0}}, in_byte_q};

    if (!fin_e) begin
      // Header and sequence byte
      if (pos_w < CMP_W'(HEADER_BYTES)) begin
        if (in_byte_q != HEADER_BYTE) begin
          verdict = 1'b1;
          code    = ERR_HEADER;
        end
      end else if (pos_w == CMP_W'(SEQ_OFFSET)) begin
        seq_d = in_byte_q;
      end

      // Length byte, compared at full width
      if (!verdict && pos_w == CMP_W'(LENGTH_OFFSET)) begin
        len_d = in_byte_q;
        if (end_w >= CMP_W'(LEN_LIMIT)) begin
          verdict = 1'b1;
          code    = ERR_LENGTH;
        end
      end

      // Tail bytes and CRC byte
      if (!verdict && pos_w > CMP_W'(LENGTH_OFFSET)) begin
        if (pos_w == tail_w || pos_w == tail_w + CMP_W'(1)) begin
          if (in_byte_q != TAIL_BYTE) begin
            verdict = 1'b1;
            code    = ERR_TAIL;
          end
        end else if (pos_w == tail_w + CMP_W'(2)) begin
          verdict = 1'b1;
          code    = (in_byte_q == crc_e) ? ERR_OK : ERR_CRC;
        end
      end
    end

    // Next state
    if (fin_e || verdict) begin
      pos_d = pos_e;
      crc_d = crc_e;
    end else begin
      pos_d = pos_e + POS_W'(1);
      crc_d = crc_next;
    end
    fin_d = fin_e || verdict;
  end

  // Control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      crc_q       <= '0;
      len_q       <= '0;
      seq_q       <= '0;
      fin_q       <= 1'b1;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= verdict;
        pos_q       <= pos_d;
        crc_q       <= crc_d;
        len_q       <= len_d;
        seq_q       <= seq_d;
        fin_q       <= fin_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
    if (advance && verdict) begin
      out_ok_q   <= (code == ERR_OK);
      out_code_q <= code;
      out_len_q  <= len_d;
      out_seq_q  <= seq_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_seq_q, out_len_q, out_code_q};
  assign m_axis_tuser  = out_ok_q;

`ifndef SYNTH
  // A verdict closes the frame
  a_verdict_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && verdict |=> fin_q)
    else $error("frame not closed after verdict");

  // A closed frame without a new start never loads a result
  a_quiet_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && fin_q && !in_start_q |=> !out_valid_q)
    else $error("result produced for a closed frame");

  // An open frame past the length byte always has a length that fits
  a_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_q && ({1'b0, pos_q} > CMP_W'(LENGTH_OFFSET)) |->
      (CMP_W'(LENGTH_OFFSET + 1) + {{(CMP_W-8){1'b0}}, len_q} < CMP_W'(LEN_LIMIT)))
    else $error("open frame with oversize length");

  // The offset counter never runs beyond the CRC byte of an open frame
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_q && ({1'b0, pos_q} > CMP_W'(LENGTH_OFFSET)) |->
      ({1'b0, pos_q} <= CMP_W'(LENGTH_OFFSET + 3) + {{(CMP_W-8){1'b0}}, len_q}))
    else $error("byte offset past end of frame");
`endif

endmodule
